// ----- src/brbo_pkg.sv -----
// ----------------------------------------------------------------------------
// brbo_pkg
// Shared types and constants of the byte ring buffer with overwrite.
// ----------------------------------------------------------------------------
package brbo_pkg;

    // default number of slots
    localparam int DEPTH_DEFAULT = 16;

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_LEN_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_OVERWRITE_PROTECT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_IN_USE = 1'd1;

    localparam logic PROTECT_RESET = 1'b1;
    localparam logic [CFG_LEN_W-1:0] LENGTH_RESET = 5'd16;

    // request codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_WRITE_REJECTED = 2'd1;
    localparam logic [1:0] ST_READ_EMPTY = 2'd2;

    typedef struct packed {
        logic       opcode;
        logic [7:0] write_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [1:0] status;
        logic       is_full;
        logic       is_empty;
        logic       error_sticky;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic do_write;
        logic do_read_empty;
        logic do_read_finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic out_busy;
    } t_status;

endpackage

// ----- src/brbo_ctrl.sv -----
// ----------------------------------------------------------------------------
// brbo_ctrl
// Controller: takes requests, sequences the read of a stored byte through S_READ.
// ----------------------------------------------------------------------------
module brbo_ctrl
    import brbo_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_opcode,
    input  t_status i_sts,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    assign accept = (r_state == S_IDLE) && i_in_valid && !i_sts.out_busy;
    assign o_in_stall = (r_state != S_IDLE) || i_sts.out_busy;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_WRITE) begin
                        o_cmd.do_write = 1'b1;
                    end else if (i_sts.empty) begin
                        o_cmd.do_read_empty = 1'b1;
                    end else begin
                        // memory read data arrives next cycle
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.do_read_finish = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/brbo_dp.sv -----
// ----------------------------------------------------------------------------
// brbo_dp
// Datapath: slot memory, ring indices, flags, config and result register.
// ----------------------------------------------------------------------------
module brbo_dp
    import brbo_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [7:0]            i_write_byte,
    input  t_cmd                  i_cmd,
    input  logic                  i_out_stall,
    output t_status               o_sts,
    output logic                  o_out_valid,
    output t_out_item             o_out_data
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW = $clog2(DEPTH + 1);
    localparam int EW = (CFG_LEN_W > DW) ? CFG_LEN_W : DW;
    localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);

    logic [7:0]           r_mem [DEPTH];
    logic [7:0]           r_mem_q;
    logic [IW-1:0]        r_rd_idx, n_rd_idx;
    logic [IW-1:0]        r_wr_idx, n_wr_idx;
    logic                 r_full, n_full;
    logic                 r_ovf, n_ovf;
    logic                 r_protect;
    logic [CFG_LEN_W-1:0] r_len;
    logic [EW-1:0]        eff_len;
    logic [IW-1:0]        rd_next, wr_next;
    logic                 mem_we;
    logic                 load_out;
    logic                 r_out_valid;
    t_out_item            r_out, n_out;

    // length in use clamped to 1..DEPTH
    always_comb begin
        if (r_len == '0) begin
            eff_len = EW'(1);
        end else if (EW'(r_len) > DEPTH_E) begin
            eff_len = DEPTH_E;
        end else begin
            eff_len = EW'(r_len);
        end
    end

    function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx,
                                               input logic [EW-1:0] len);
        logic [EW:0] n;
        n = {1'b0, EW'(idx)} + (EW+1)'(1);
        if (n >= {1'b0, len}) begin
            return '0;
        end
        return n[IW-1:0];
    endfunction

    assign rd_next = next_idx(r_rd_idx, eff_len);
    assign wr_next = next_idx(r_wr_idx, eff_len);

    assign o_sts.empty = (r_wr_idx == r_rd_idx) && !r_full;
    assign o_sts.out_busy = r_out_valid && i_out_stall;

    always_comb begin
        n_rd_idx = r_rd_idx;
        n_wr_idx = r_wr_idx;
        n_full = r_full;
        n_ovf = r_ovf;
        mem_we = 1'b0;
        load_out = 1'b0;
        n_out = '0;
        n_out.status = ST_DONE;
        if (i_cmd.do_write) begin
            load_out = 1'b1;
            if (r_protect && r_full) begin
                n_ovf = 1'b1;
                n_out.status = ST_WRITE_REJECTED;
            end else begin
                mem_we = 1'b1;
                // overwrite drops the oldest byte
                if (r_full) begin
                    n_rd_idx = rd_next;
                end
                n_wr_idx = wr_next;
                n_full = (wr_next == n_rd_idx);
            end
        end else if (i_cmd.do_read_empty) begin
            load_out = 1'b1;
            n_out.status = ST_READ_EMPTY;
        end else if (i_cmd.do_read_finish) begin
            load_out = 1'b1;
            n_out.read_byte = r_mem_q;
            n_full = 1'b0;
            n_ovf = 1'b0;
            n_rd_idx = rd_next;
        end
        n_out.is_full = n_full;
        n_out.is_empty = (n_wr_idx == n_rd_idx) && !n_full;
        n_out.error_sticky = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_idx] <= i_write_byte;
        end
        r_mem_q <= r_mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
            r_wr_idx <= '0;
            r_full <= 1'b0;
            r_ovf <= 1'b0;
            r_protect <= PROTECT_RESET;
            r_len <= LENGTH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_idx <= n_rd_idx;
            r_wr_idx <= n_wr_idx;
            r_full <= n_full;
            r_ovf <= n_ovf;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OVERWRITE_PROTECT: r_protect <= i_cfg_data[0];
                    CFG_LENGTH_IN_USE: r_len <= i_cfg_data[CFG_LEN_W-1:0];
                    default: ;
                endcase
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

endmodule

// ----- src/byte_ring_buffer_overwrite.sv -----
// ----------------------------------------------------------------------------
// byte_ring_buffer_overwrite
// Byte ring buffer with write rejection or overwrite when full.
//
//   channel  direction  signals
//   in       input      i_in_valid, o_in_stall, i_in_data (t_in_item)
//   out      output     o_out_valid, i_out_stall, o_out_data (t_out_item)
//   cfg      input      i_cfg_we, i_cfg_index, i_cfg_data
//
// A write or a read of an empty buffer loads the output register directly;
// a read of a stored byte first passes the registered slot memory read port.
// Each item's result sits in an output register; a new item is taken while
// the controller is idle and that register is free or emptied in that cycle.
// Synchronous active-low reset returns indices, flags, config and the
// output valid to their reset values; the slot memory is not cleared.
// ----------------------------------------------------------------------------
module byte_ring_buffer_overwrite
    import brbo_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    t_cmd    cmd;
    t_status sts;

    brbo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_data.opcode),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    brbo_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_write_byte (i_in_data.write_byte),
        .i_cmd        (cmd),
        .i_out_stall  (i_out_stall),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data)
    );

endmodule
